### hw/rtl/otb_pkg.sv
package otb_pkg;

  localparam int unsigned NUM_TIMERS_DEF    = 8;
  localparam int unsigned TICK_WIDTH_DEF    = 32;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned MAX_RESULTS       = 8;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DEST_W  = 8;
  localparam int unsigned ESIZE_W = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned SIZE_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_CHECK = 3'd4,
    OP_TICK  = 3'd5
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_FIRED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_RESP
  } state_e;

  // low size bytes set, size of eight or more gives all ones
  function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (SIZE_W'(b) < size) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### hw/rtl/otb_if.sv
interface otb_in_if;
  logic                         valid;
  logic                         ready;
  logic [otb_pkg::OP_W-1:0]     operation;
  logic [otb_pkg::ID_W-1:0]     timer_id;
  logic [otb_pkg::DEST_W-1:0]   destination;
  logic [otb_pkg::ESIZE_W-1:0]  event_size;
  logic [otb_pkg::DATA_W-1:0]   event_data;
  logic [otb_pkg::DELAY_W-1:0]  delay_ticks;

  modport source (output valid, operation, timer_id, destination, event_size,
                  event_data, delay_ticks, input ready);
  modport sink (input valid, operation, timer_id, destination, event_size,
                event_data, delay_ticks, output ready);
endinterface

interface otb_out_if;
  logic                         valid;
  logic                         ready;
  logic [otb_pkg::KIND_W-1:0]   kind;
  logic                         ok;
  logic [otb_pkg::INDEX_W-1:0]  index;
  logic                         running;
  logic [otb_pkg::DEST_W-1:0]   fired_destination;
  logic [otb_pkg::DATA_W-1:0]   fired_data;
  logic [otb_pkg::SIZE_W-1:0]   fired_size;
  logic                         last;

  modport source (output valid, kind, ok, index, running, fired_destination,
                  fired_data, fired_size, last, input ready);
  modport sink (input valid, kind, ok, index, running, fired_destination,
                fired_data, fired_size, last, output ready);
endinterface

### hw/rtl/one_shot_event_timer_bank.sv
// channel | dir | modport           | word
// in_i    | in  | otb_in_if.sink    | operation, timer_id, tag, size, payload, delay
// out_o   | out | otb_out_if.source | kind, ok, index, running, tag, payload, size, last
//
// one item at a time; stop, check, bad ids and unused codes pass through the response state,
// free and start through the read and modify states (read, then write back the entry memory)
// tick reads every entry, alloc reads up to the first free entry k (every entry if full)
// reset clears the tick count, armed flags and entry written flags, no clearing pass
// a stalled output holds the sequencer; the next word is taken while a result waits
module one_shot_event_timer_bank #(
  parameter int unsigned NUM_TIMERS    = otb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TICK_WIDTH    = otb_pkg::TICK_WIDTH_DEF,
  parameter int unsigned PAYLOAD_BYTES = otb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  otb_in_if.sink    in_i,
  otb_out_if.source out_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned PW = 8 * PAYLOAD_BYTES;
  localparam int unsigned FW = $clog2(otb_pkg::MAX_RESULTS + 1);
  localparam int unsigned DW = (TICK_WIDTH > otb_pkg::DELAY_W) ? TICK_WIDTH
                                                                : otb_pkg::DELAY_W;

  typedef struct packed {
    logic [otb_pkg::DEST_W-1:0] dest;
    logic [otb_pkg::SIZE_W-1:0] size;
    logic [PW-1:0]              pay;
    logic [TICK_WIDTH-1:0]      dl;
  } entry_t;

  otb_pkg::state_e state_q, state_d;

  otb_pkg::op_e                op_q;
  logic [otb_pkg::ID_W-1:0]    id_q;
  logic [otb_pkg::DEST_W-1:0]  dest_q;
  logic [otb_pkg::ESIZE_W-1:0] esize_q;
  logic [PW-1:0]               data_q;
  logic [otb_pkg::DELAY_W-1:0] delay_q;

  logic [TICK_WIDTH-1:0] count_q;
  logic [NUM_TIMERS-1:0] run_q;
  logic [NUM_TIMERS-1:0] wr_q;

  entry_t mem_q [NUM_TIMERS];
  entry_t rd_data_q;

  logic [CW-1:0] scan_q;
  logic          pend_q;
  logic [IW-1:0] pend_idx_q;
  logic [FW-1:0] fires_q;

  logic                       hold_v_q;
  logic [IW-1:0]              hold_idx_q;
  logic [otb_pkg::DEST_W-1:0] hold_dest_q;
  logic [PW-1:0]              hold_data_q;
  logic [otb_pkg::SIZE_W-1:0] hold_size_q;

  logic                        out_valid_q;
  otb_pkg::kind_e              out_kind_q;
  logic                        out_ok_q;
  logic [otb_pkg::INDEX_W-1:0] out_index_q;
  logic                        out_running_q;
  logic [otb_pkg::DEST_W-1:0]  out_dest_q;
  logic [otb_pkg::DATA_W-1:0]  out_data_q;
  logic [otb_pkg::SIZE_W-1:0]  out_size_q;
  logic                        out_last_q;

  otb_pkg::op_e in_op;
  logic         accept;
  logic         can_load;
  logic         id_ok;
  logic         in_id_ok;

  logic                       ent_wr;
  logic [otb_pkg::DEST_W-1:0] ent_dest;
  logic [otb_pkg::SIZE_W-1:0] ent_size;
  logic [PW-1:0]              ent_pay;
  logic [TICK_WIDTH-1:0]      ent_dl;
  logic [PW-1:0]              mask_pw;
  logic [DW-1:0]              delay_ext;
  logic [TICK_WIDTH-1:0]      start_dl;
  logic [otb_pkg::SIZE_W-1:0] clamp_size;

  logic scan_end;
  logic alloc_hit;
  logic tick_hit;
  logic scan_stall;
  logic scan_fin;

  logic          in_ready;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          run_set;
  logic          run_clr;
  logic [IW-1:0] run_idx;
  logic          wr_set;
  logic          hold_load;
  logic          hold_clr;

  logic                        out_load;
  otb_pkg::kind_e              res_kind;
  logic                        res_ok;
  logic [otb_pkg::INDEX_W-1:0] res_index;
  logic                        res_running;
  logic [otb_pkg::DEST_W-1:0]  res_dest;
  logic [otb_pkg::DATA_W-1:0]  res_data;
  logic [otb_pkg::SIZE_W-1:0]  res_size;
  logic                        res_last;

  assign in_op    = otb_pkg::op_e'(in_i.operation);
  assign accept   = in_i.valid && in_ready;
  assign can_load = !out_valid_q || out_o.ready;
  assign id_ok    = id_q < otb_pkg::ID_W'(NUM_TIMERS);
  assign in_id_ok = in_i.timer_id < otb_pkg::ID_W'(NUM_TIMERS);

  // never written entries read as free, empty and zero payload
  assign ent_wr   = wr_q[pend_idx_q];
  assign ent_dest = ent_wr ? rd_data_q.dest : '0;
  assign ent_size = ent_wr ? rd_data_q.size : '0;
  assign ent_pay  = ent_wr ? rd_data_q.pay : '0;
  assign ent_dl   = rd_data_q.dl;

  assign mask_pw    = PW'(otb_pkg::byte_mask(ent_size));
  assign delay_ext  = DW'(delay_q);
  assign start_dl   = count_q + delay_ext[TICK_WIDTH-1:0] + TICK_WIDTH'(1);
  assign clamp_size = (esize_q > otb_pkg::ESIZE_W'(PAYLOAD_BYTES))
                    ? otb_pkg::SIZE_W'(PAYLOAD_BYTES) : esize_q[otb_pkg::SIZE_W-1:0];

  assign scan_end  = !pend_q && (scan_q == CW'(NUM_TIMERS));
  assign alloc_hit = pend_q && (ent_dest == '0);
  assign tick_hit  = pend_q && run_q[pend_idx_q] && (ent_dl == count_q)
                  && (fires_q < FW'(otb_pkg::MAX_RESULTS));

  // a fire result waits in the hold stage until we know whether another follows
  always_comb begin
    if (op_q == otb_pkg::OP_ALLOC) begin
      scan_stall = (alloc_hit || scan_end) && !can_load;
      scan_fin   = (alloc_hit || scan_end) && can_load;
    end else begin
      scan_stall = hold_v_q && !can_load && (tick_hit || scan_end);
      scan_fin   = scan_end && (!hold_v_q || can_load);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == otb_pkg::OP_ALLOC || in_op == otb_pkg::OP_TICK) begin
            state_d = otb_pkg::ST_SCAN;
          end else if ((in_op == otb_pkg::OP_FREE || in_op == otb_pkg::OP_START)
                       && in_id_ok) begin
            state_d = otb_pkg::ST_READ;
          end else begin
            state_d = otb_pkg::ST_RESP;
          end
        end
      end
      otb_pkg::ST_READ: begin
        state_d = otb_pkg::ST_MODIFY;
      end
      otb_pkg::ST_MODIFY: begin
        if (can_load) state_d = otb_pkg::ST_IDLE;
      end
      otb_pkg::ST_SCAN: begin
        if (scan_fin) state_d = otb_pkg::ST_IDLE;
      end
      otb_pkg::ST_RESP: begin
        if (can_load) state_d = otb_pkg::ST_IDLE;
      end
      default: begin
        state_d = otb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_q[IW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = pend_idx_q;
    mem_wdata   = rd_data_q;
    run_set     = 1'b0;
    run_clr     = 1'b0;
    run_idx     = pend_idx_q;
    wr_set      = 1'b0;
    hold_load   = 1'b0;
    hold_clr    = 1'b0;
    out_load    = 1'b0;
    res_kind    = otb_pkg::KIND_ACK;
    res_ok      = 1'b0;
    res_index   = '0;
    res_running = 1'b0;
    res_dest    = '0;
    res_data    = '0;
    res_size    = '0;
    res_last    = 1'b1;
    unique case (state_q)
      otb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      otb_pkg::ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = id_q[IW-1:0];
      end
      otb_pkg::ST_MODIFY: begin
        if (can_load) begin
          mem_we    = 1'b1;
          mem_waddr = id_q[IW-1:0];
          wr_set    = 1'b1;
          run_idx   = id_q[IW-1:0];
          out_load  = 1'b1;
          res_ok    = 1'b1;
          mem_wdata.size = ent_size;
          if (op_q == otb_pkg::OP_START) begin
            mem_wdata.dest = ent_dest;
            mem_wdata.pay  = data_q & mask_pw;
            mem_wdata.dl   = start_dl;
            run_set        = 1'b1;
          end else begin
            mem_wdata.dest = '0;
            mem_wdata.pay  = ent_pay;
            mem_wdata.dl   = ent_dl;
            run_clr        = 1'b1;
          end
        end
      end
      otb_pkg::ST_SCAN: begin
        if (!scan_stall && (scan_q != CW'(NUM_TIMERS))) begin
          rd_en   = 1'b1;
          rd_addr = scan_q[IW-1:0];
        end
        if (op_q == otb_pkg::OP_ALLOC) begin
          res_kind = otb_pkg::KIND_ALLOC;
          if (alloc_hit && can_load) begin
            mem_we         = 1'b1;
            mem_wdata.dest = dest_q;
            mem_wdata.size = clamp_size;
            mem_wdata.pay  = ent_pay;
            mem_wdata.dl   = ent_dl;
            wr_set         = 1'b1;
            run_clr        = 1'b1;
            out_load       = 1'b1;
            res_ok         = 1'b1;
            res_index      = otb_pkg::INDEX_W'(pend_idx_q);
          end else if (scan_end && can_load) begin
            out_load = 1'b1;
          end
        end else begin
          res_kind  = otb_pkg::KIND_FIRED;
          res_ok    = 1'b1;
          res_index = otb_pkg::INDEX_W'(hold_idx_q);
          res_dest  = hold_dest_q;
          res_data  = otb_pkg::DATA_W'(hold_data_q);
          res_size  = hold_size_q;
          if (tick_hit && !scan_stall) begin
            run_clr   = 1'b1;
            hold_load = 1'b1;
            out_load  = hold_v_q;
            res_last  = 1'b0;
          end else if (scan_end && hold_v_q && can_load) begin
            out_load = 1'b1;
            hold_clr = 1'b1;
          end
        end
      end
      otb_pkg::ST_RESP: begin
        run_idx = id_q[IW-1:0];
        if (can_load) begin
          out_load = 1'b1;
          unique case (op_q)
            otb_pkg::OP_STOP: begin
              res_ok  = id_ok;
              run_clr = id_ok;
            end
            otb_pkg::OP_CHECK: begin
              res_kind    = otb_pkg::KIND_STATUS;
              res_ok      = id_ok;
              res_running = id_ok && run_q[id_q[IW-1:0]];
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= otb_pkg::ST_IDLE;
      count_q     <= '0;
      run_q       <= '0;
      wr_q        <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      fires_q     <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        scan_q  <= '0;
        pend_q  <= 1'b0;
        fires_q <= '0;
        if (in_op == otb_pkg::OP_TICK) count_q <= count_q + TICK_WIDTH'(1);
      end else if (state_q == otb_pkg::ST_SCAN && !scan_stall) begin
        if (rd_en) scan_q <= scan_q + CW'(1);
        pend_q <= rd_en;
      end
      if (hold_load) fires_q <= fires_q + FW'(1);
      if (run_clr) run_q[run_idx] <= 1'b0;
      if (run_set) run_q[run_idx] <= 1'b1;
      if (wr_set) wr_q[mem_waddr] <= 1'b1;
      if (hold_load) begin
        hold_v_q <= 1'b1;
      end else if (hold_clr) begin
        hold_v_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      id_q    <= in_i.timer_id;
      dest_q  <= in_i.destination;
      esize_q <= in_i.event_size;
      data_q  <= in_i.event_data[PW-1:0];
      delay_q <= in_i.delay_ticks;
    end
    if (rd_en) pend_idx_q <= rd_addr;
    if (hold_load) begin
      hold_idx_q  <= pend_idx_q;
      hold_dest_q <= ent_dest;
      hold_data_q <= ent_pay & mask_pw;
      hold_size_q <= ent_size;
    end
    if (out_load) begin
      out_kind_q    <= res_kind;
      out_ok_q      <= res_ok;
      out_index_q   <= res_index;
      out_running_q <= res_running;
      out_dest_q    <= res_dest;
      out_data_q    <= res_data;
      out_size_q    <= res_size;
      out_last_q    <= res_last;
    end
  end

  assign in_i.ready              = in_ready;
  assign out_o.valid             = out_valid_q;
  assign out_o.kind              = out_kind_q;
  assign out_o.ok                = out_ok_q;
  assign out_o.index             = out_index_q;
  assign out_o.running           = out_running_q;
  assign out_o.fired_destination = out_dest_q;
  assign out_o.fired_data        = out_data_q;
  assign out_o.fired_size        = out_size_q;
  assign out_o.last              = out_last_q;

  a_hold_empty_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !hold_v_q)
    else $error("fire result still held when a new word is taken");

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("entry memory read and written at the same address");

  a_armed_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q & ~wr_q) == '0)
    else $error("armed timer whose entry was never written");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_load |-> (fires_q < FW'(otb_pkg::MAX_RESULTS)))
    else $error("more fire results than allowed in one tick");

endmodule
